FILE: sv/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16LE stream decoder.
package u8u16_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned PEND_W  = 2;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  // Register map: word index taken from paddr[2].
  localparam logic REG_MAX_UNITS = 1'b0;

  localparam logic [COUNT_W-1:0] MAX_UNITS_RST = 7'd126;

  // Surrogate range 0xD800..0xDFFF is 11011xxx_xxxxxxxx.
  localparam logic [4:0] SURR_TOP = 5'b11011;

  localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

  typedef struct packed {
    logic [UNIT_W-1:0]  code_unit;
    logic               bad_sequence;
    logic               string_done;
    logic [COUNT_W-1:0] unit_count;
  } result_t;

endpackage

FILE: sv/utf8_to_utf16le_stream_top.sv
// Top level of the UTF-8 to UTF-16LE stream decoder.
//
//  channel   dir  handshake                    payload
//  --------  ---  ---------------------------  ------------------------------------
//  in        in   in_valid_i / in_ready_o      in_byte_i, string_start_i
//  out       out  out_valid_o / out_ready_i    code_unit_o, bad_sequence_o,
//                                              string_done_o, unit_count_o
//  apb cfg   in   psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// One byte per cycle. A byte is decoded in the cycle it is accepted and its
// result (if any) sits in the output register from the next cycle on.
// in_ready_o is high whenever the output register is empty or being drained,
// so bytes stream back to back as long as the consumer keeps up.
// Reset clears decode state and loads max_units with 126.
// A stalled consumer holds the output register and blocks further input.
module utf8_to_utf16le_stream_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [u8u16_pkg::BYTE_W-1:0]  in_byte_i,
  input  logic                          string_start_i,
  // code unit output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [u8u16_pkg::UNIT_W-1:0]  code_unit_o,
  output logic                          bad_sequence_o,
  output logic                          string_done_o,
  output logic [u8u16_pkg::COUNT_W-1:0] unit_count_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [u8u16_pkg::APB_AW-1:0]  paddr,
  input  logic [u8u16_pkg::APB_DW-1:0]  pwdata,
  output logic [u8u16_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import u8u16_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] max_units_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_UNITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= MAX_UNITS_RST;
    end else if (cfg_wr) begin
      max_units_q <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_UNITS) begin
      prdata = {{(APB_DW-COUNT_W){1'b0}}, max_units_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Decode state
  // ---------------------------------------------------------------------------
  logic [UNIT_W-1:0]  partial_q, partial_d;
  logic [PEND_W-1:0]  pend_q, pend_d;
  logic [COUNT_W-1:0] units_q, units_d;
  logic               halted_q, halted_d;

  logic               out_valid_q;
  result_t            res_q, res_d;
  logic               emit;
  logic               in_xfer;

  // Output register frees up in the same cycle it is drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Scratch values for the decode step.
  logic [UNIT_W-1:0]  part_cur;
  logic [PEND_W-1:0]  pend_cur;
  logic [COUNT_W-1:0] units_cur;
  logic [COUNT_W-1:0] units_inc;
  logic               halted_cur;
  logic [UNIT_W-1:0]  merged;

  always_comb begin
    // string start wipes the slate before the byte is looked at
    part_cur   = string_start_i ? '0 : partial_q;
    pend_cur   = string_start_i ? PEND_NONE : pend_q;
    units_cur  = string_start_i ? '0 : units_q;
    halted_cur = string_start_i ? 1'b0 : halted_q;
    units_inc  = units_cur + COUNT_W'(1);

    // continuation payload: bits 11:6 for first of two, 5:0 otherwise
    if (pend_cur == PEND_TWO) begin
      merged = part_cur | {4'd0, in_byte_i[5:0], 6'd0};
    end else begin
      merged = part_cur | {10'd0, in_byte_i[5:0]};
    end

    partial_d = part_cur;
    pend_d    = pend_cur;
    units_d   = units_cur;
    halted_d  = halted_cur;
    emit      = 1'b0;
    res_d     = '{code_unit: '0, bad_sequence: 1'b0, string_done: 1'b1,
                  unit_count: units_cur};

    if (!halted_cur) begin
      if (units_cur >= max_units_q) begin
        // limit already met: bare end marker
        emit     = 1'b1;
        halted_d = 1'b1;
      end else if (pend_cur != PEND_NONE) begin
        if (in_byte_i[7:6] != 2'b10) begin
          emit               = 1'b1;
          res_d.bad_sequence = 1'b1;
          halted_d           = 1'b1;
        end else begin
          partial_d = merged;
          pend_d    = pend_cur - PEND_W'(1);
          if (pend_cur == PEND_ONE) begin
            emit = 1'b1;
            if (merged[15:11] == SURR_TOP) begin
              res_d.bad_sequence = 1'b1;
              halted_d           = 1'b1;
            end else begin
              units_d           = units_inc;
              res_d.code_unit   = merged;
              res_d.unit_count  = units_inc;
              res_d.string_done = (units_inc >= max_units_q);
              halted_d          = (units_inc >= max_units_q);
            end
          end
        end
      end else if (in_byte_i == '0) begin
        // terminator
        emit     = 1'b1;
        halted_d = 1'b1;
      end else if (!in_byte_i[7]) begin
        // plain ASCII
        emit              = 1'b1;
        units_d           = units_inc;
        res_d.code_unit   = {8'd0, in_byte_i};
        res_d.unit_count  = units_inc;
        res_d.string_done = (units_inc >= max_units_q);
        halted_d          = (units_inc >= max_units_q);
      end else if (in_byte_i[7:5] == 3'b110) begin
        partial_d = {5'd0, in_byte_i[4:0], 6'd0};
        pend_d    = PEND_ONE;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        partial_d = {in_byte_i[3:0], 12'd0};
        pend_d    = PEND_TWO;
      end else begin
        // stray continuation or four-byte lead
        emit               = 1'b1;
        res_d.bad_sequence = 1'b1;
        halted_d           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      pend_q      <= PEND_NONE;
      units_q     <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        partial_q   <= partial_d;
        pend_q      <= pend_d;
        units_q     <= units_d;
        halted_q    <= halted_d;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_unit_o    = res_q.code_unit;
  assign bad_sequence_o = res_q.bad_sequence;
  assign string_done_o  = res_q.string_done;
  assign unit_count_o   = res_q.unit_count;

endmodule

FILE: sv/u8u16_chk.sv
// Port-level checker for the UTF-8 to UTF-16LE stream decoder, with its bind.
module u8u16_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] code_unit_o,
  input logic        bad_sequence_o,
  input logic        string_done_o,
  input logic [6:0]  unit_count_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // empty output register never blocks input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // rejected encodings always end the string with a zero unit
  a_bad_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_sequence_o) |-> (string_done_o && code_unit_o == 16'd0))
    else $error("bad sequence result not a terminal zero unit");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(code_unit_o)
      && $stable(unit_count_o) && $stable(string_done_o)))
    else $error("stalled result changed");

  // written limit reads back
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2]) |=>
      (paddr[2] || prdata[6:0] == $past(pwdata[6:0])))
    else $error("max_units readback mismatch");

endmodule

bind utf8_to_utf16le_stream_top u8u16_chk u_chk (.*);

FILE: tb/utf8_to_utf16le_stream_top_tb.sv
// Self-checking testbench for the UTF-8 to UTF-16LE stream decoder top level.
`timescale 1ns / 100ps

module utf8_to_utf16le_stream_top_tb;
  import u8u16_pkg::*;

  // Register 0 sits at byte address 0.
  localparam logic [APB_AW-1:0] LIMIT_ADDR = {REG_MAX_UNITS, 2'b00};

  // One staged byte: the UTF-8 value and whether it opens a new string.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              first;
  } utf8_byte_t;

  // ------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input has a known value from time 0.
  // ------------------------------------------------------------------
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [BYTE_W-1:0]  in_byte_i      = '0;
  logic               string_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [UNIT_W-1:0]  code_unit_o;
  logic               bad_sequence_o;
  logic               string_done_o;
  logic [COUNT_W-1:0] unit_count_o;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [APB_AW-1:0]  paddr          = '0;
  logic [APB_DW-1:0]  pwdata         = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  utf8_to_utf16le_stream_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .string_start_i (string_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_unit_o    (code_unit_o),
    .bad_sequence_o (bad_sequence_o),
    .string_done_o  (string_done_o),
    .unit_count_o   (unit_count_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // ------------------------------------------------------------------
  // Decoder shadow state. Starts out as after reset; only the driver's
  // transfers and register writes (done while idle) move it.
  // ------------------------------------------------------------------
  logic [COUNT_W-1:0] limit_cfg   = MAX_UNITS_RST;
  logic [UNIT_W-1:0]  dec_partial = '0;
  logic [PEND_W-1:0]  dec_pending = PEND_NONE;
  logic [COUNT_W-1:0] dec_units   = '0;
  logic               dec_halted  = 1'b0;

  result_t    units_due[$];   // predicted results, oldest first
  utf8_byte_t byte_queue[$];  // bytes waiting for the driver

  // Idle rates in percent per decision point; the stimulus process sets them per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_gap      = 0;

  int unsigned fault_count   = 0;
  int unsigned staged        = 0;
  int unsigned bytes_taken   = 0;
  int unsigned units_checked = 0;
  int unsigned rejects_seen  = 0;
  int unsigned ends_seen     = 0;

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  // Queue one result; a string-ending result stops decoding until the next start.
  function automatic void emit(input logic [UNIT_W-1:0] unit, input logic bad,
                               input logic done);
    result_t r;
    r.code_unit    = unit;
    r.bad_sequence = bad;
    r.string_done  = done;
    r.unit_count   = dec_units;
    if (done) dec_halted = 1'b1;
    units_due.push_back(r);
  endfunction

  function automatic void emit_unit(input logic [UNIT_W-1:0] unit);
    dec_units = dec_units + 1'b1;
    emit(unit, 1'b0, dec_units >= limit_cfg);
  endfunction

  // Advance the shadow decoder by one accepted byte.
  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic first);
    if (first) begin
      dec_partial = '0;
      dec_pending = PEND_NONE;
      dec_units   = '0;
      dec_halted  = 1'b0;
    end
    if (dec_halted) return;
    // limit already met, e.g. lowered below the count mid-string
    if (dec_units >= limit_cfg) begin
      emit('0, 1'b0, 1'b1);
      return;
    end
    if (dec_pending != PEND_NONE) begin
      if (b[7:6] != 2'b10) begin
        emit('0, 1'b1, 1'b1);
        return;
      end
      if (dec_pending == PEND_TWO) dec_partial = dec_partial | {4'b0, b[5:0], 6'b0};
      else                         dec_partial = dec_partial | {10'b0, b[5:0]};
      dec_pending = dec_pending - 1'b1;
      if (dec_pending != PEND_NONE) return;
      if (dec_partial >= 16'hD800 && dec_partial <= 16'hDFFF) emit('0, 1'b1, 1'b1);
      else emit_unit(dec_partial);
      return;
    end
    if (b == '0) begin
      emit('0, 1'b0, 1'b1);             // terminator
    end else if (!b[7]) begin
      emit_unit({8'h00, b});
    end else if (b[7:5] == 3'b110) begin
      dec_partial = {5'b0, b[4:0], 6'b0};
      dec_pending = PEND_ONE;
    end else if (b[7:4] == 4'b1110) begin
      dec_partial = {b[3:0], 12'b0};
      dec_pending = PEND_TWO;
    end else begin
      emit('0, 1'b1, 1'b1);             // stray continuation or four-byte lead
    end
  endfunction

  // ------------------------------------------------------------------
  // Input driver: feeds byte_queue into the byte channel, with random
  // idle bursts. Payload only changes after a transfer.
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    utf8_byte_t nxt;
    logic       took;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      took = in_valid_i && in_ready_o;
      if (took) begin
        decode_byte(in_byte_i, string_start_i);
        bytes_taken++;
      end
      if (!in_valid_i || took) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (byte_queue.size() != 0 && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 13);
          in_valid_i <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          nxt = byte_queue.pop_front();
          in_valid_i     <= 1'b1;
          in_byte_i      <= nxt.value;
          string_start_i <= nxt.first;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Output monitor: checks each result transfer against the oldest
  // prediction and applies random back-pressure.
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.code_unit    = code_unit_o;
        got.bad_sequence = bad_sequence_o;
        got.string_done  = string_done_o;
        got.unit_count   = unit_count_o;
        if (units_due.size() == 0) begin
          log_fault($sformatf("unexpected result unit=%h bad=%b done=%b count=%0d",
                              got.code_unit, got.bad_sequence, got.string_done,
                              got.unit_count));
        end else begin
          want = units_due.pop_front();
          units_checked++;
          if (want.bad_sequence) rejects_seen++;
          else if (want.string_done) ends_seen++;
          if (got.code_unit !== want.code_unit || got.bad_sequence !== want.bad_sequence ||
              got.string_done !== want.string_done || got.unit_count !== want.unit_count)
            log_fault($sformatf({"expected unit=%h bad=%b done=%b count=%0d, ",
                                 "got unit=%h bad=%b done=%b count=%0d"},
                                want.code_unit, want.bad_sequence, want.string_done,
                                want.unit_count, got.code_unit, got.bad_sequence,
                                got.string_done, got.unit_count));
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(0, 13);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  task automatic stage_byte(input logic [BYTE_W-1:0] value, input logic first);
    utf8_byte_t item;
    item.value = value;
    item.first = first;
    byte_queue.push_back(item);
    staged++;
  endtask

  function automatic logic [BYTE_W-1:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // Any byte that is not 10xxxxxx, zero included.
  function automatic logic [BYTE_W-1:0] other_byte();
    logic [BYTE_W-1:0] b;
    b = 8'($urandom);
    if (b[7:6] == 2'b10) b[6] = 1'b1;
    return b;
  endfunction

  // One character. Clean picks stay within valid non-surrogate encodings.
  task automatic stage_char(input bit clean, input bit first);
    int unsigned       pick;
    logic [BYTE_W-1:0] lead;
    pick = clean ? $urandom_range(0, 85) : $urandom_range(0, 99);
    if (pick < 40) begin
      stage_byte(8'($urandom_range(1, 127)), first);
    end else if (pick < 62) begin
      stage_byte(8'($urandom_range(8'hC0, 8'hDF)), first);
      stage_byte(cont_byte(), 1'b0);
    end else if (pick < 86) begin
      lead = 8'($urandom_range(8'hE0, 8'hEF));
      stage_byte(lead, first);
      // after ED keep the second byte in 80..9F so it stays clear of surrogates
      stage_byte(lead == 8'hED ? {3'b100, 5'($urandom)} : cont_byte(), 1'b0);
      stage_byte(cont_byte(), 1'b0);
    end else if (pick < 89) begin
      // surrogate half encoded in three bytes
      stage_byte(8'hED, first);
      stage_byte({3'b101, 5'($urandom)}, 1'b0);
      stage_byte(cont_byte(), 1'b0);
    end else if (pick < 92) begin
      // continuation or four-byte lead in lead position
      stage_byte($urandom_range(0, 1) ? {2'b10, 6'($urandom)} : {4'hF, 4'($urandom)}, first);
    end else if (pick < 95) begin
      stage_byte(8'($urandom_range(8'hC0, 8'hDF)), first);
      stage_byte(other_byte(), 1'b0);
    end else if (pick < 97) begin
      // three-byte sequence broken in its last byte
      stage_byte(8'($urandom_range(8'hE0, 8'hEF)), first);
      stage_byte(cont_byte(), 1'b0);
      stage_byte(other_byte(), 1'b0);
    end else begin
      stage_byte(8'($urandom), first);
    end
  endtask

  // A string, mostly zero terminated; some are left open and the next start cuts them.
  task automatic stage_string(input int unsigned n_chars, input bit clean);
    int unsigned tail;
    for (int unsigned i = 0; i < n_chars; i++) stage_char(clean, i == 0);
    tail = $urandom_range(0, 99);
    if (tail < 80) begin
      stage_byte(8'h00, 1'b0);
      // trailing bytes after the end are dropped by the block
      if (tail >= 65) repeat ($urandom_range(1, 3)) stage_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic stage_strings(input int unsigned budget, input int unsigned longest);
    int unsigned goal;
    goal = staged + budget;
    while (staged < goal) stage_string($urandom_range(1, longest), $urandom_range(0, 3) != 0);
  endtask

  // Sender holds off until every predicted result has arrived, then allows
  // time for a lead byte that produces nothing.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (byte_queue.size() != 0 || in_valid_i || units_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Read back the current limit, then write the new one. Called only while idle.
  task automatic program_limit(input logic [COUNT_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (prdata[COUNT_W-1:0] !== limit_cfg)
      log_fault($sformatf("max_units read expected %0d, got %0d",
                          limit_cfg, prdata[COUNT_W-1:0]));
    penable <= 1'b0;
    pwrite  <= 1'b1;
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    limit_cfg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    // {string start, byte}
    static logic [8:0] opening [26] = '{
      // no start since reset: decodes at once; then terminator; then ignored
      {1'b0, 8'h41}, {1'b0, 8'h00}, {1'b0, 8'h42},
      // ASCII top, smallest two-byte, largest three-byte, last below surrogates,
      // overlong zero accepted, terminator
      {1'b1, 8'h7F}, {1'b0, 8'hC2}, {1'b0, 8'h80},
      {1'b0, 8'hEF}, {1'b0, 8'hBF}, {1'b0, 8'hBF},
      {1'b0, 8'hED}, {1'b0, 8'h9F}, {1'b0, 8'hBF},
      {1'b0, 8'hE0}, {1'b0, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'h00},
      // surrogate value, stray continuation, 0xFF lead, four-byte lead
      {1'b1, 8'hED}, {1'b0, 8'hA0}, {1'b0, 8'h80},
      {1'b1, 8'h80}, {1'b1, 8'hFF}, {1'b1, 8'hF0},
      // zero and 11xxxxxx where a continuation belongs
      {1'b1, 8'hC3}, {1'b0, 8'h00}, {1'b1, 8'hE1}, {1'b0, 8'hC0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 10;
    recv_idle_pct = 10;
    foreach (opening[i]) stage_byte(opening[i][7:0], opening[i][8]);
    wait_drained();

    // reset limit, sender-side idling only
    send_idle_pct = 20;
    recv_idle_pct = 0;
    stage_strings(200, 12);
    wait_drained();

    // widest limit: one long clean string runs into 127 units
    program_limit(7'd127);
    send_idle_pct = 0;
    recv_idle_pct = 20;
    stage_string(130, 1'b1);
    stage_strings(60, 12);
    wait_drained();

    // narrowest limit: no string goes past its first unit
    program_limit(7'd1);
    send_idle_pct = 15;
    recv_idle_pct = 15;
    stage_strings(80, 4);
    wait_drained();

    // leave a string open at 5 units, then drop the limit under it;
    // the next byte without a start must end the string with a zero unit
    program_limit(7'd126);
    for (int i = 0; i < 5; i++) stage_byte(8'h61 + 8'(i), i == 0);
    wait_drained();
    program_limit(7'd3);
    stage_byte(8'h41, 1'b0);
    stage_byte(8'h42, 1'b0);
    wait_drained();

    repeat (3) begin
      program_limit(7'($urandom_range(2, 20)));
      send_idle_pct = $urandom_range(0, 25);
      recv_idle_pct = $urandom_range(0, 25);
      stage_strings(100, 10);
      wait_drained();
    end

    // closing stretch at full rate, back to the reset limit
    program_limit(MAX_UNITS_RST);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stage_strings(290, 16);
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("run covered %0d bytes in and %0d results checked (%0d rejected, %0d other ends)",
             bytes_taken, units_checked, rejects_seen, ends_seen);
    $display("limits 1, 3, 126, 127 and random ones; %0d mismatches", fault_count);
    if (fault_count == 0 && units_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
sv/u8u16_pkg.sv
sv/utf8_to_utf16le_stream_top.sv
sv/u8u16_chk.sv
tb/utf8_to_utf16le_stream_top_tb.sv
